@@ rtl/core/srd_pkg.sv @@
// Shared types and constants for the silence region detector.
package srd_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int THRESH_BITS = 24;
    localparam int RUN_BITS    = 24;
    localparam int USED_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [MAG_BITS-1:0]           mag_t;
    typedef logic [RUN_BITS-1:0]           run_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_THRESHOLD   = 2'd0;
    localparam cfg_idx_t REG_MIN_SILENCE = 2'd1;
    localparam cfg_idx_t REG_CHANNELS    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RST   = '0;
    localparam run_t                   MIN_SILENCE_RST = run_t'(1);
    localparam logic [USED_BITS-1:0]   CHANNELS_RST    = 3'd2;

    typedef struct packed {
        logic [THRESH_BITS-1:0] threshold;
        run_t                   min_silence_samples;
        logic [USED_BITS-1:0]   channels_in_use;
    } cfg_t;

endpackage

@@ rtl/core/silence_region_detector_top.sv @@
// Top level of the silence region detector.
//
// Usage: one multichannel audio frame per sample transaction (sample_valid,
// sample_stall). A frame whose peak over the channels in use is below
// threshold is silent. A closed loud region comes out as one region
// transaction (region_valid, region_stall) carrying region_start and
// region_end. A frame with end_of_stream set closes an open region at the
// frame count and clears the region state and the count.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no frame is in flight.
// Flow: a frame is registered on acceptance and evaluated once the result
// register is free or being emptied; its region is loaded into the result register.
// Throughput: one frame per cycle unless the held result is stalled.
// Stall: the result register holds under region_stall; a new frame still
// enters the input register, and sample_stall rises only while both the
// input register and the result register are full and the result is stalled.
// Reset: rst_n clears the region state, frame count, pending result and the
// configuration registers to threshold 0, minimum silence 1, two channels.
module silence_region_detector_top
    import srd_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample_ch0,
    input  sample_t                sample_ch1,
    input  sample_t                sample_ch2,
    input  sample_t                sample_ch3,
    input  logic                   end_of_stream,
    output logic                   region_valid,
    input  logic                   region_stall,
    output logic [INDEX_BITS-1:0]  region_start,
    output logic [INDEX_BITS-1:0]  region_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_idx_t               cfg_index,
    input  logic [THRESH_BITS-1:0] cfg_data
);

    cfg_t                  cfg_reg;
    logic                  frame_valid_reg;
    sample_t               frame_samples_reg [CHANNELS];
    logic                  frame_eos_reg;
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] out_start_reg;
    logic [INDEX_BITS-1:0] out_end_reg;

    logic                  accept;
    logic                  advance;
    mag_t                  peak;
    logic                  emit;
    logic [INDEX_BITS-1:0] emit_start;
    logic [INDEX_BITS-1:0] emit_end;

    assign cfg_ready = 1'b1;

    // Write configuration registers; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold           <= THRESHOLD_RST;
            cfg_reg.min_silence_samples <= MIN_SILENCE_RST;
            cfg_reg.channels_in_use     <= CHANNELS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD:   cfg_reg.threshold           <= cfg_data;
                REG_MIN_SILENCE: cfg_reg.min_silence_samples <= run_t'(cfg_data);
                REG_CHANNELS:    cfg_reg.channels_in_use     <= cfg_data[USED_BITS-1:0];
                default:         cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Evaluate the held frame when the result register is free or being emptied
    assign advance      = frame_valid_reg && (!out_valid_reg || !region_stall);
    assign sample_stall = frame_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    // Hold the incoming frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            frame_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            frame_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_samples_reg[0] <= sample_ch0;
            frame_samples_reg[1] <= sample_ch1;
            frame_samples_reg[2] <= sample_ch2;
            frame_samples_reg[3] <= sample_ch3;
            frame_eos_reg        <= end_of_stream;
        end
    end

    srd_peak u_peak (
        .samples         (frame_samples_reg),
        .channels_in_use (cfg_reg.channels_in_use),
        .peak            (peak)
    );

    srd_tracker #(
        .INDEX_BITS (INDEX_BITS)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .end_of_stream (frame_eos_reg),
        .peak          (peak),
        .cfg           (cfg_reg),
        .emit          (emit),
        .emit_start    (emit_start),
        .emit_end      (emit_end)
    );

    // Load the result register on each evaluated frame; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!region_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_start_reg <= emit_start;
            out_end_reg   <= emit_end;
        end
    end

    assign region_valid = out_valid_reg;
    assign region_start = out_start_reg;
    assign region_end   = out_end_reg;

endmodule

@@ rtl/core/srd_peak.sv @@
// Peak magnitude over the channels in use of one frame.
module srd_peak
    import srd_pkg::*;
(
    input  sample_t               samples [CHANNELS],
    input  logic [USED_BITS-1:0]  channels_in_use,
    output mag_t                  peak
);

    logic [USED_BITS-1:0] used;
    mag_t                 mag [CHANNELS];
    logic [MAG_BITS-1:0]  ext [CHANNELS];

    // Saturate the channel count to the channels present
    assign used = (channels_in_use > USED_BITS'(CHANNELS)) ? USED_BITS'(CHANNELS)
                                                           : channels_in_use;

    // Take the magnitude of each sample; full-scale negative gives 2^(SAMPLE_BITS-1)
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            ext[ch] = {samples[ch][SAMPLE_BITS-1], samples[ch]};
            mag[ch] = samples[ch][SAMPLE_BITS-1] ? (~ext[ch] + MAG_BITS'(1)) : ext[ch];
        end
    end

    // Keep the largest magnitude among the channels in use
    always_comb
    begin
        peak = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if ((USED_BITS'(ch) < used) && (mag[ch] > peak))
            begin
                peak = mag[ch];
            end
        end
    end

endmodule

@@ rtl/core/srd_tracker.sv @@
// Region state: open region, silence run, frame count and the closing decision.
module srd_tracker
    import srd_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  end_of_stream,
    input  mag_t                  peak,
    input  cfg_t                  cfg,
    output logic                  emit,
    output logic [INDEX_BITS-1:0] emit_start,
    output logic [INDEX_BITS-1:0] emit_end
);

    logic                  in_region_reg,   in_region_next;
    run_t                  silent_run_reg,  silent_run_next;
    logic [INDEX_BITS-1:0] open_start_reg,  open_start_next;
    logic [INDEX_BITS-1:0] frame_index_reg, frame_index_next;

    logic                  loud;
    run_t                  run_inc;
    logic [INDEX_BITS-1:0] close_end;

    assign loud      = peak >= {1'b0, cfg.threshold};
    assign run_inc   = silent_run_reg + run_t'(1);
    assign close_end = frame_index_reg - INDEX_BITS'(run_inc);

    // Work out the next region state and any closed region for this frame
    always_comb
    begin
        in_region_next   = in_region_reg;
        silent_run_next  = silent_run_reg;
        open_start_next  = open_start_reg;
        frame_index_next = frame_index_reg + INDEX_BITS'(1);
        emit             = 1'b0;
        emit_start       = open_start_reg;
        emit_end         = close_end;

        if (end_of_stream)
        begin
            emit             = in_region_reg && (frame_index_reg > open_start_reg);
            emit_end         = frame_index_reg;
            in_region_next   = 1'b0;
            silent_run_next  = '0;
            open_start_next  = '0;
            frame_index_next = '0;
        end
        else if (loud)
        begin
            if (!in_region_reg)
            begin
                in_region_next  = 1'b1;
                open_start_next = frame_index_reg;
            end
            silent_run_next = '0;
        end
        else if (in_region_reg)
        begin
            if (run_inc >= cfg.min_silence_samples)
            begin
                emit            = close_end > open_start_reg;
                in_region_next  = 1'b0;
                silent_run_next = '0;
            end
            else
            begin
                silent_run_next = run_inc;
            end
        end
    end

    // Advance the state on each frame that moves forward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_region_reg   <= 1'b0;
            silent_run_reg  <= '0;
            open_start_reg  <= '0;
            frame_index_reg <= '0;
        end
        else if (step)
        begin
            in_region_reg   <= in_region_next;
            silent_run_reg  <= silent_run_next;
            open_start_reg  <= open_start_next;
            frame_index_reg <= frame_index_next;
        end
    end

endmodule

@@ rtl/core/srd_checker.sv @@
// Port-level checks for the silence region detector, bound to the top level.
module srd_checker
    import srd_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_stall,
    input logic                  region_valid,
    input logic                  region_stall,
    input logic [INDEX_BITS-1:0] region_start,
    input logic [INDEX_BITS-1:0] region_end
);

    // No region transaction is offered in the first cycle out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !region_valid)
        else $error("region offered straight out of reset");

    // A reported region always ends after it starts
    assert property (@(posedge clk) disable iff (!rst_n)
        region_valid |-> (region_end > region_start))
        else $error("region end not after region start");

    // Hold a stalled region transaction unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (region_valid && region_stall) |=>
            (region_valid && $stable(region_start) && $stable(region_end)))
        else $error("stalled region transaction changed");

    // Input stall only while a pending result is itself stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (region_valid && region_stall))
        else $error("sample stall without a stalled result");

endmodule

bind silence_region_detector_top srd_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_srd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .region_valid (region_valid),
    .region_stall (region_stall),
    .region_start (region_start),
    .region_end   (region_end)
);

@@ test/srd_region_monitor.sv @@
// Region monitor: tracks the silence state of the frame stream and checks each region transaction.
`timescale 1ns / 1ps

module srd_region_monitor
    import srd_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   sample_stall,
    input  sample_t                sample_ch0,
    input  sample_t                sample_ch1,
    input  sample_t                sample_ch2,
    input  sample_t                sample_ch3,
    input  logic                   end_of_stream,
    input  logic                   region_valid,
    input  logic                   region_stall,
    input  logic [INDEX_BITS-1:0]  region_start,
    input  logic [INDEX_BITS-1:0]  region_end,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  cfg_idx_t               cfg_index,
    input  logic [THRESH_BITS-1:0] cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     regions_checked
);

    typedef logic [INDEX_BITS-1:0] index_t;

    typedef struct packed {
        index_t start_idx;
        index_t end_idx;
    } region_t;

    // Regions predicted but not yet seen on the output
    region_t regions_due[$];

    // Shadow copy of the configuration registers
    logic [THRESH_BITS-1:0] threshold_q;
    run_t                   min_quiet_q;
    logic [USED_BITS-1:0]   used_ch_q;

    // Shadow copy of the region tracking state
    logic   region_open;
    run_t   quiet_run;
    index_t open_start;
    index_t frame_count;

    region_t closed_now;
    region_t oldest;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("region monitor: mismatch: %s", msg);
        mismatches++;
    endtask

    // Magnitude of a two's complement sample; full-scale negative gives 2^23
    function automatic mag_t sample_magnitude(input sample_t s);
        if (s[SAMPLE_BITS-1])
            return (mag_t'(1) << SAMPLE_BITS) - mag_t'({1'b0, s});
        return mag_t'({1'b0, s});
    endfunction

    // Advance the tracker by one frame; return 1 when a region closes
    function automatic logic track_frame(input sample_t s0, input sample_t s1,
                                         input sample_t s2, input sample_t s3,
                                         input logic eos, output region_t closed);
        sample_t frame [CHANNELS];
        mag_t    peak;
        mag_t    m;
        int      used;
        int      c;
        index_t  end_idx;
        logic    emit;

        emit   = 1'b0;
        closed = '0;

        // End of stream: close at the frame count, then clear everything
        if (eos)
        begin
            if (region_open && frame_count > open_start)
            begin
                closed.start_idx = open_start;
                closed.end_idx   = frame_count;
                emit = 1'b1;
            end
            region_open = 1'b0;
            quiet_run   = '0;
            open_start  = '0;
            frame_count = '0;
            return emit;
        end

        frame[0] = s0;
        frame[1] = s1;
        frame[2] = s2;
        frame[3] = s3;
        used = (int'(used_ch_q) > CHANNELS) ? CHANNELS : int'(used_ch_q);

        // Peak over the channels in use
        peak = '0;
        for (c = 0; c < used; c++)
        begin
            m = sample_magnitude(frame[c]);
            if (m > peak)
                peak = m;
        end

        if (peak >= mag_t'(threshold_q))
        begin
            if (!region_open)
            begin
                region_open = 1'b1;
                open_start  = frame_count;
            end
            quiet_run = '0;
        end
        else if (region_open)
        begin
            quiet_run = quiet_run + run_t'(1);
            if (quiet_run >= min_quiet_q)
            begin
                end_idx = frame_count - index_t'(quiet_run);
                if (end_idx > open_start)
                begin
                    closed.start_idx = open_start;
                    closed.end_idx   = end_idx;
                    emit = 1'b1;
                end
                region_open = 1'b0;
                quiet_run   = '0;
            end
        end

        frame_count = frame_count + index_t'(1);
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_due.delete();
            threshold_q     = THRESHOLD_RST;
            min_quiet_q     = MIN_SILENCE_RST;
            used_ch_q       = CHANNELS_RST;
            region_open     = 1'b0;
            quiet_run       = '0;
            open_start      = '0;
            frame_count     = '0;
            mismatches      = 0;
            pending         = 0;
            regions_checked = 0;
        end
        else
        begin
            // Compare a leaving region transaction with the oldest prediction
            if (region_valid && !region_stall)
            begin
                if (regions_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected region start %0d end %0d",
                                              region_start, region_end));
                end
                else
                begin
                    oldest = regions_due.pop_front();
                    regions_checked++;
                    if (region_start !== oldest.start_idx)
                        report_mismatch($sformatf("region_start %0d, want %0d",
                                                  region_start, oldest.start_idx));
                    if (region_end !== oldest.end_idx)
                        report_mismatch($sformatf("region_end %0d, want %0d",
                                                  region_end, oldest.end_idx));
                end
            end

            // Follow register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD:   threshold_q = cfg_data;
                    REG_MIN_SILENCE: min_quiet_q = run_t'(cfg_data);
                    REG_CHANNELS:    used_ch_q   = cfg_data[USED_BITS-1:0];
                    default: ;
                endcase
            end

            // Predict from each accepted frame transaction
            if (sample_valid && !sample_stall)
            begin
                if (track_frame(sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                                end_of_stream, closed_now))
                    regions_due.insert(regions_due.size(), closed_now);
            end

            pending = regions_due.size();
        end
    end

endmodule

@@ test/tb.sv @@
// Testbench top: drives frames and register writes into the detector and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import srd_pkg::*;

    localparam int          INDEX_BITS    = 40;
    localparam int unsigned FULL_SCALE    = 32'd8388608;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          MAX_IDLE      = 18;

    localparam sample_t SAMPLE_MAX = sample_t'(24'h7FFFFF);
    localparam sample_t SAMPLE_MIN = sample_t'(24'h800000);

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_t                sample_ch0;
    sample_t                sample_ch1;
    sample_t                sample_ch2;
    sample_t                sample_ch3;
    logic                   end_of_stream;
    logic                   region_valid;
    logic                   region_stall;
    logic [INDEX_BITS-1:0]  region_start;
    logic [INDEX_BITS-1:0]  region_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index;
    logic [THRESH_BITS-1:0] cfg_data;

    int mismatches;
    int pending;
    int regions_checked;

    // Current settings, kept in step with the register writes
    int unsigned cur_threshold;
    int unsigned cur_min;
    int unsigned cur_ch;

    bit tx_fast;
    bit rx_fast;
    int frames_sent;
    int eos_sent;
    int settings_applied;
    int cycle_count;

    silence_region_detector_top #(
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_ch0    (sample_ch0),
        .sample_ch1    (sample_ch1),
        .sample_ch2    (sample_ch2),
        .sample_ch3    (sample_ch3),
        .end_of_stream (end_of_stream),
        .region_valid  (region_valid),
        .region_stall  (region_stall),
        .region_start  (region_start),
        .region_end    (region_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    srd_region_monitor #(
        .INDEX_BITS (INDEX_BITS)
    ) region_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample_ch0      (sample_ch0),
        .sample_ch1      (sample_ch1),
        .sample_ch2      (sample_ch2),
        .sample_ch3      (sample_ch3),
        .end_of_stream   (end_of_stream),
        .region_valid    (region_valid),
        .region_stall    (region_stall),
        .region_start    (region_start),
        .region_end      (region_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .regions_checked (regions_checked)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d regions outstanding",
                     cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Region receiver: hold stall for a random count, then take one transaction
    initial
    begin : region_sink
        int hold;
        region_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = rx_fast ? 0 : $urandom_range(MAX_IDLE, 0);
            if (hold > 0)
            begin
                region_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            region_stall <= 1'b0;
            @(posedge clk);
            while (!(region_valid && !region_stall))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Present one frame transaction after a random gap and hold it until taken
    task automatic send_frame(input sample_t s0, input sample_t s1, input sample_t s2,
                              input sample_t s3, input logic eos);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid  <= 1'b1;
        sample_ch0    <= s0;
        sample_ch1    <= s1;
        sample_ch2    <= s2;
        sample_ch3    <= s3;
        end_of_stream <= eos;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
        frames_sent++;
    endtask

    // End of stream with random ignored samples
    task automatic send_eos();
        send_frame(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                   sample_t'($urandom), 1'b1);
        eos_sent++;
    endtask

    task automatic send_noise();
        send_frame(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                   sample_t'($urandom), 1'b0);
    endtask

    // Sample of the given magnitude with a random sign where one is possible
    function automatic sample_t signed_sample(input int unsigned mag);
        if (mag == 0)
            return '0;
        if (mag >= FULL_SCALE)
            return SAMPLE_MIN;
        if ($urandom_range(1, 0) == 1)
            return sample_t'(-int'(mag));
        return sample_t'(mag);
    endfunction

    // Magnitude in [lo, hi], half the time close to the threshold edge
    function automatic int unsigned pick_mag(input int unsigned lo, input int unsigned hi,
                                             input bit near_low);
        int unsigned span;
        span = (hi - lo < 16) ? hi - lo : 16;
        if ($urandom_range(1, 0) == 1)
            return near_low ? lo + $urandom_range(span, 0) : hi - $urandom_range(span, 0);
        return $urandom_range(hi, lo);
    endfunction

    // Frame that is loud or silent under the current settings
    task automatic send_level(input bit loud);
        sample_t     s [4];
        int          used;
        int          i;
        int          j;
        int unsigned top_quiet;
        used = (cur_ch == 0) ? 0 : ((cur_ch > 4) ? 4 : int'(cur_ch));
        for (i = 0; i < 4; i++)
        begin
            if (i < used && cur_threshold > 0)
            begin
                top_quiet = (cur_threshold - 1 > FULL_SCALE) ? FULL_SCALE : cur_threshold - 1;
                s[i] = signed_sample(pick_mag(0, top_quiet, 1'b0));
            end
            else
            begin
                s[i] = sample_t'($urandom);
            end
        end
        if (loud && used > 0 && cur_threshold <= FULL_SCALE)
        begin
            j = $urandom_range(used - 1, 0);
            s[j] = signed_sample(pick_mag(cur_threshold, FULL_SCALE, 1'b1));
        end
        send_frame(s[0], s[1], s[2], s[3], 1'b0);
    endtask

    // Silence run around the closing length
    function automatic int quiet_run_length();
        int base;
        int r;
        base = (cur_min == 0) ? 1 : int'(cur_min);
        if (base > 20)
            return $urandom_range(12, 0);
        r = $urandom_range(9, 0);
        if (r < 3)
            return base - 1;
        if (r < 7)
            return base;
        return base + $urandom_range(3, 1);
    endfunction

    // Wait until no region is outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [THRESH_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain, let in-flight frames settle, then write all three registers
    task automatic configure(input int unsigned thr, input int unsigned min_quiet,
                             input int unsigned ch);
        sample_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(REG_THRESHOLD, THRESH_BITS'(thr));
        write_register(REG_MIN_SILENCE, THRESH_BITS'(min_quiet));
        write_register(REG_CHANNELS, THRESH_BITS'(ch));
        cfg_valid <= 1'b0;
        cur_threshold = thr;
        cur_min       = min_quiet;
        cur_ch        = ch;
        settings_applied++;
    endtask

    // One random phase: mostly loud bursts followed by silence runs
    task automatic run_phase(input int unsigned thr, input int unsigned min_quiet,
                             input int unsigned ch, input int items,
                             input bit fast_tx, input bit fast_rx);
        int sent;
        int burst;
        int run_len;
        int k;
        int roll;
        bit paused;
        configure(thr, min_quiet, ch);
        tx_fast = fast_tx;
        rx_fast = fast_rx;
        sent    = 0;
        paused  = 1'b0;
        while (sent < items)
        begin
            // Halfway through, hold off until every region has come out
            if (!paused && sent >= items / 2)
            begin
                paused = 1'b1;
                sample_valid <= 1'b0;
                wait_drained();
            end
            roll = $urandom_range(99, 0);
            if (roll < 75)
            begin
                burst = $urandom_range(6, 1);
                for (k = 0; k < burst; k++)
                    send_level(1'b1);
                run_len = quiet_run_length();
                for (k = 0; k < run_len; k++)
                    send_level(1'b0);
                sent += burst + run_len;
                if ($urandom_range(9, 0) == 0)
                begin
                    send_eos();
                    sent++;
                end
            end
            else if (roll < 90)
            begin
                burst = $urandom_range(5, 1);
                for (k = 0; k < burst; k++)
                    send_noise();
                sent += burst;
            end
            else
            begin
                send_eos();
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample_ch0    = '0;
        sample_ch1    = '0;
        sample_ch2    = '0;
        sample_ch3    = '0;
        end_of_stream = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_THRESHOLD;
        cfg_data      = '0;
        cur_threshold = THRESHOLD_RST;
        cur_min       = MIN_SILENCE_RST;
        cur_ch        = CHANNELS_RST;
        tx_fast       = 1'b0;
        rx_fast       = 1'b0;
        frames_sent      = 0;
        eos_sent         = 0;
        settings_applied = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero threshold, so every frame is loud
        send_frame('0, '0, '0, '0, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_eos();
        send_eos();

        // Full-scale threshold: only the full-scale negative sample reaches it
        configure(FULL_SCALE, 2, 4);
        send_frame('0, '0, '0, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MAX, sample_t'(24'h800001), '0, '0, 1'b0);
        send_frame('0, '0, '0, '0, 1'b0);
        send_frame(SAMPLE_MIN, '0, '0, '0, 1'b0);
        send_frame('0, SAMPLE_MIN, '0, '0, 1'b0);
        send_frame(SAMPLE_MAX, '0, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_frame('0, '0, '0, '0, 1'b0);

        // Channel count above the limit, zero minimum silence, peak equal to threshold
        configure(32'h400000, 0, 7);
        send_frame('0, '0, '0, sample_t'(24'h400000), 1'b0);
        send_frame('0, '0, '0, sample_t'(24'hC00000), 1'b0);
        send_frame(sample_t'(24'h3FFFFF), sample_t'(24'hC00001),
                   sample_t'(24'h3FFFFF), sample_t'(24'hC00001), 1'b0);

        // No channels in use: every frame silent, end of stream with nothing open
        configure(256, 1, 0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_eos();

        // Threshold above full scale: nothing is loud
        configure(32'hFFFFFF, 1, 4);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);

        // Single channel, smallest threshold, end of stream inside a silence run
        configure(1, 3, 1);
        send_frame(sample_t'(24'h000001), '0, '0, '0, 1'b0);
        send_frame('0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_frame(sample_t'(24'hFFFFFF), '0, '0, '0, 1'b0);
        send_frame('0, '0, '0, '0, 1'b0);
        send_frame('0, '0, '0, '0, 1'b0);
        send_eos();

        // Random phases over a spread of settings
        run_phase(32'h200000, 3, 2, 200, 1'b0, 1'b0);
        run_phase(FULL_SCALE, 1, 4, 200, 1'b0, 1'b0);
        run_phase(1, 4, 1, 180, 1'b0, 1'b1);
        run_phase(32'h123456, 0, 7, 180, 1'b1, 1'b1);
        run_phase(32'h7FFFFF, 32'hFFFFFF, 3, 150, 1'b0, 1'b0);
        run_phase(32'h050000, 12, 4, 200, 1'b1, 1'b0);
        run_phase(32'h300000, 2, 0, 60, 1'b0, 1'b0);
        run_phase(32'h00A000, 2, 5, 230, 1'b0, 1'b0);

        // Drain and let the pipeline run empty
        sample_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d frames (%0d end of stream) over %0d register settings",
                 frames_sent, eos_sent, settings_applied);
        $display("tb: %0d regions compared, %0d mismatches", regions_checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
